[design/gmms_pkg.sv]
// Shared constants and controller/datapath command and status types
// for the group mean max select block. No dependencies.
package gmms_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int ADDR_BITS    = $clog2(MAX_ELEMENTS);
    localparam int CNT_BITS     = $clog2(MAX_ELEMENTS + 1);
    localparam int GC_BITS      = 7;
    localparam int DIV_BITS     = ((CNT_BITS > GC_BITS) ? CNT_BITS : GC_BITS) + 1;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
    localparam int SUM_BITS     = SAMPLE_BITS + ADDR_BITS + 1;
    localparam int PROD_BITS    = SUM_BITS + CNT_BITS + 1;

    typedef struct packed {
        logic load;       // store one sample transfer
        logic div_init;   // set up numerator and divisor
        logic div_step;   // one quotient bit
        logic scan_init;  // clear scan counters and best chunk
        logic scan_read;  // read element at scan index
        logic scan_acc;   // add read element to running sum
        logic score_mul;  // register cross products
        logic score_cmp;  // compare and close chunk
        logic emit_rd;    // read one element of the winning chunk
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic chunk_end;
        logic scan_done;
        logic emit_last;
    } t_status;

endpackage

[design/gmms_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module gmms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/gmms_ctrl.sv]
// Sequencer for load, divide, score and emit phases.
// Depends on gmms_pkg for the command and status structs.
module gmms_ctrl import gmms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_last,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);
    typedef enum logic [2:0] {
        S_LOAD, S_PREP, S_DIV, S_RD, S_ACC, S_MUL, S_CMP, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                o_cmd.load = accept;
                if (accept && i_last) n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.scan_read = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.scan_acc = 1'b1;
                n_state = i_status.chunk_end ? S_MUL : S_RD;
            end
            S_MUL: begin
                o_cmd.score_mul = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.score_cmp = 1'b1;
                n_state = i_status.scan_done ? S_EMIT : S_RD;
            end
            S_EMIT: begin
                o_cmd.emit_rd = 1'b1;
                if (i_status.emit_last) n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_LOAD);
        end
    end

    assign o_busy = r_busy;

    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_LOAD))
        else $error("busy out of step with state");
    a_last_leaves_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last |=> r_state == S_PREP)
        else $error("last transfer did not start scoring");
    a_emit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && i_status.emit_last |=> !r_busy)
        else $error("emit did not return to loading");
endmodule

[design/gmms_dp.sv]
// Datapath: sample store, serial divider, chunk scorer and emit pipeline.
// Depends on gmms_pkg and gmms_ram.
module gmms_dp import gmms_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic                   i_cfg_wr_en,
    input  logic [GC_BITS-1:0]     i_cfg_wr_data,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_value,
    output logic                   o_final_res,
    output logic                   o_overflow,
    output logic                   o_strobe
);
    logic [GC_BITS-1:0]          r_group_count;
    logic [CNT_BITS-1:0]         r_count;
    logic                        r_ovf;
    logic [DIV_BITS-1:0]         r_quo;
    logic [GC_BITS-1:0]          r_rem;
    logic [DIV_CNT_BITS-1:0]     r_div_cnt;
    logic [CNT_BITS-1:0]         r_idx;
    logic [CNT_BITS-1:0]         r_pos;
    logic [ADDR_BITS-1:0]        r_chunk_start;
    logic signed [SUM_BITS-1:0]  r_sum;
    logic signed [SUM_BITS-1:0]  r_best_sum;
    logic [CNT_BITS-1:0]         r_best_size;
    logic [ADDR_BITS-1:0]        r_best_start;
    logic signed [PROD_BITS-1:0] r_prod_new;
    logic signed [PROD_BITS-1:0] r_prod_best;
    logic [CNT_BITS-1:0]         r_emit_k;
    logic                        r_out_valid;
    logic                        r_out_final;
    logic                        r_out_ovf;

    logic [GC_BITS-1:0]     groups;
    logic [GC_BITS:0]       rem_sh;
    logic                   q_bit;
    logic [CNT_BITS-1:0]    chunk;
    logic [CNT_BITS-1:0]    idx_inc;
    logic [CNT_BITS-1:0]    pos_inc;
    logic [CNT_BITS-1:0]    emit_inc;
    logic                   has_room;
    logic                   mem_we;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SUM_BITS-1:0]    rd_ext;

    assign groups   = (r_group_count == '0) ? GC_BITS'(1) : r_group_count;
    assign rem_sh   = {r_rem, r_quo[DIV_BITS-1]};
    assign q_bit    = (rem_sh >= {1'b0, groups});
    assign chunk    = r_quo[CNT_BITS-1:0];
    assign idx_inc  = r_idx + CNT_BITS'(1);
    assign pos_inc  = r_pos + CNT_BITS'(1);
    assign emit_inc = r_emit_k + CNT_BITS'(1);
    assign has_room = (r_count < CNT_BITS'(MAX_ELEMENTS));
    assign mem_we   = i_cmd.load && has_room;
    assign rd_addr  = i_cmd.emit_rd ? (r_best_start + r_emit_k[ADDR_BITS-1:0])
                                    : r_idx[ADDR_BITS-1:0];
    assign rd_ext   = {{(SUM_BITS - SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};

    assign o_status.div_last  = (r_div_cnt == '0);
    assign o_status.chunk_end = (pos_inc == chunk) || (idx_inc == r_count);
    assign o_status.scan_done = (r_idx == r_count);
    assign o_status.emit_last = (emit_inc == r_best_size);

    gmms_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_ELEMENTS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_count[ADDR_BITS-1:0]),
        .i_wdata(i_sample),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= GC_BITS'(1);
            r_count       <= '0;
            r_ovf         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_group_count <= i_cfg_wr_data;
            if (i_cmd.load) begin
                if (has_room) r_count <= r_count + CNT_BITS'(1);
                else          r_ovf   <= 1'b1;
            end
            if (i_cmd.emit_rd && o_status.emit_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            r_out_valid <= i_cmd.emit_rd;
        end
    end

    // divider, scorer and emit payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo     <= DIV_BITS'(r_count) + DIV_BITS'(groups) - DIV_BITS'(1);
            r_rem     <= '0;
            r_div_cnt <= DIV_CNT_BITS'(DIV_BITS - 1);
        end
        if (i_cmd.div_step) begin
            r_rem     <= q_bit ? GC_BITS'(rem_sh - {1'b0, groups}) : rem_sh[GC_BITS-1:0];
            r_quo     <= {r_quo[DIV_BITS-2:0], q_bit};
            r_div_cnt <= r_div_cnt - DIV_CNT_BITS'(1);
        end
        if (i_cmd.scan_init) begin
            r_idx         <= '0;
            r_pos         <= '0;
            r_chunk_start <= '0;
            r_sum         <= '0;
            r_best_size   <= '0;
        end
        if (i_cmd.scan_acc) begin
            r_sum <= r_sum + $signed(rd_ext);
            r_idx <= idx_inc;
            r_pos <= pos_inc;
        end
        if (i_cmd.score_mul) begin
            r_prod_new  <= r_sum * $signed({1'b0, r_best_size});
            r_prod_best <= r_best_sum * $signed({1'b0, r_pos});
        end
        if (i_cmd.score_cmp) begin
            // strict greater keeps the earlier chunk on equal means
            if (r_best_size == '0 || r_prod_new > r_prod_best) begin
                r_best_sum   <= r_sum;
                r_best_size  <= r_pos;
                r_best_start <= r_chunk_start;
            end
            r_sum         <= '0;
            r_pos         <= '0;
            r_chunk_start <= r_idx[ADDR_BITS-1:0];
            r_emit_k      <= '0;
        end
        if (i_cmd.emit_rd) r_emit_k <= emit_inc;
        r_out_final <= o_status.emit_last;
        r_out_ovf   <= r_ovf;
    end

    assign o_value     = rd_data;
    assign o_final_res = r_out_final;
    assign o_overflow  = r_out_ovf;
    assign o_strobe    = r_out_valid;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_ELEMENTS))
        else $error("element count beyond capacity");
    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_final |=> !r_out_valid)
        else $error("result after final transfer");
    a_emit_sized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_rd |-> r_best_size != '0 && r_best_size <= chunk)
        else $error("winning chunk size out of range");
    a_chunk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_read |-> chunk != '0)
        else $error("chunk size zero while scanning");
endmodule

[design/group_mean_max_select.sv]
// Top level of the group mean max select block: controller plus datapath.
// Depends on gmms_pkg, gmms_ctrl, gmms_dp and gmms_ram.
//
//  channel   handshake              payload
//  input     start, busy            i_sample, i_last
//  result    o_strobe (no stall)    o_value, o_final_res, o_overflow
//  config    i_cfg_wr_en            i_cfg_wr_data (group count)
//
// Busy stays low while loading. After the last transfer: a set-up step,
// a serial divider for the chunk size, then scoring, which reads each stored
// element and closes each chunk, then one result per cycle; scoring and emit
// are paced by the single read port of the store.
// Reset is synchronous, active low; the sample store is not cleared.
// Results cannot be held off: each is shown on o_strobe for one cycle.
module group_mean_max_select import gmms_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_last,
    input  logic                   i_cfg_wr_en,
    input  logic [GC_BITS-1:0]     i_cfg_wr_data,
    output logic                   o_strobe,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output logic                   o_final_res,
    output logic                   o_overflow
);
    t_cmd    cmd;
    t_status status;
    logic [SAMPLE_BITS-1:0] value;

    gmms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_last),
        .i_status(status),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    gmms_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_sample     (i_sample),
        .o_value      (value),
        .o_final_res  (o_final_res),
        .o_overflow   (o_overflow),
        .o_strobe     (o_strobe)
    );

    assign o_value = $signed(value);
endmodule

[verif/group_mean_max_select_tb.sv]
// Self-checking testbench for group_mean_max_select: drives sample vectors,
// group-count writes and idle bursts, and checks every emitted element.
// Depends on gmms_pkg and the group_mean_max_select design files.
module group_mean_max_select_tb;
    import gmms_pkg::*;

    localparam int RANDOM_ITEMS  = 384;
    localparam int PLAN_ROWS     = 26;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 16;
    localparam int QUIET_LIMIT   = 2000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          final_res;
        logic                          overflow;
    } t_pick;

    typedef struct packed {
        logic                   cfg;
        logic [GC_BITS-1:0]     gc;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
        logic                   typed;
        logic [SAMPLE_BITS-1:0] typed_value;
    } t_plan_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          i_last = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [GC_BITS-1:0]            i_cfg_wr_data = '0;
    logic                          o_strobe;
    logic signed [SAMPLE_BITS-1:0] o_value;
    logic                          o_final_res;
    logic                          o_overflow;

    // predictor state
    logic signed [SAMPLE_BITS-1:0] held_samples [MAX_ELEMENTS];
    int                            held_count = 0;
    logic                          held_overflow = 1'b0;
    logic [GC_BITS-1:0]            group_setting = 7'd1;

    t_pick     expected_picks [$];
    t_pick     fresh_picks [$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    t_plan_row plan [PLAN_ROWS];

    group_mean_max_select u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_sample      (i_sample),
        .i_last        (i_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_strobe      (o_strobe),
        .o_value       (o_value),
        .o_final_res   (o_final_res),
        .o_overflow    (o_overflow)
    );

    always #6 i_clk = ~i_clk;

    // Store one sample; on the last one score every chunk and queue the winner.
    function automatic void absorb_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                          input logic lst);
        int     n, groups, chunk, first, stop, win_group, win_size, g, i;
        longint chunk_sum, win_sum;
        t_pick  pick;
        fresh_picks.delete();
        if (held_count < MAX_ELEMENTS) begin
            held_samples[held_count] = s;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (!lst) return;
        n         = held_count;
        groups    = (group_setting == 0) ? 1 : int'(group_setting);
        chunk     = (n + groups - 1) / groups;
        win_size  = 0;
        win_sum   = 0;
        win_group = 0;
        for (g = 0; g < groups; g++) begin
            first = g * chunk;
            if (first >= n) break;
            stop = (first + chunk > n) ? n : first + chunk;
            chunk_sum = 0;
            for (i = first; i < stop; i++) chunk_sum += longint'(held_samples[i]);
            // exact mean comparison by cross products; ties keep the earlier chunk
            if (win_size == 0 || chunk_sum * win_size > win_sum * (stop - first)) begin
                win_sum   = chunk_sum;
                win_size  = stop - first;
                win_group = g;
            end
        end
        for (i = 0; i < win_size; i++) begin
            pick.value     = held_samples[win_group * chunk + i];
            pick.final_res = (i == win_size - 1);
            pick.overflow  = held_overflow;
            fresh_picks.insert(fresh_picks.size(), pick);
        end
        held_count    = 0;
        held_overflow = 1'b0;
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic lst,
                               input logic typed, input logic [SAMPLE_BITS-1:0] tv);
        t_pick typed_pick;
        start    <= 1'b1;
        i_sample <= s;
        i_last   <= lst;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        absorb_sample(s, lst);
        if (typed) begin
            typed_pick.value     = tv;
            typed_pick.final_res = 1'b1;
            typed_pick.overflow  = 1'b0;
            expected_picks.insert(expected_picks.size(), typed_pick);
        end else begin
            foreach (fresh_picks[i])
                expected_picks.insert(expected_picks.size(), fresh_picks[i]);
        end
    endtask

    task automatic hold_off();
        start <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge i_clk);
    endtask

    // Write the group count only once the block has drained.
    task automatic set_groups(input logic [GC_BITS-1:0] gc);
        start <= 1'b0;
        while (expected_picks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= gc;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        group_setting = gc;
    endtask

    function automatic logic [GC_BITS-1:0] pick_groups();
        case ($urandom_range(0, 6))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd2;
            3:       return 7'd64;
            4:       return 7'd127;
            5:       return GC_BITS'($urandom_range(0, 127));
            default: return GC_BITS'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return SAMPLE_BITS'($urandom_range(0, 16) - 8);
            default: return SAMPLE_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && o_strobe) begin
            if (expected_picks.size() == 0) begin
                $display("%0t unexpected result: value %0d final %0b overflow %0b",
                         $time, o_value, o_final_res, o_overflow);
                mismatches++;
            end else begin
                want = expected_picks.pop_front();
                if (o_value !== want.value) begin
                    $display("%0t value mismatch: expected %0d, actual %0d",
                             $time, want.value, o_value);
                    mismatches++;
                end
                if (o_final_res !== want.final_res) begin
                    $display("%0t final_res mismatch: expected %0b, actual %0b",
                             $time, want.final_res, o_final_res);
                    mismatches++;
                end
                if (o_overflow !== want.overflow) begin
                    $display("%0t overflow mismatch: expected %0b, actual %0b",
                             $time, want.overflow, o_overflow);
                    mismatches++;
                end
            end
        end
    end

    // Count cycles with no transfer on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int sent, vec, len, k;
        plan = '{
            '{1'b0, 7'd0,   16'h7FFF, 1'b1, 1'b1, 16'h7FFF},
            '{1'b0, 7'd0,   16'h8000, 1'b1, 1'b1, 16'h8000},
            '{1'b0, 7'd0,   16'h0000, 1'b1, 1'b1, 16'h0000},
            '{1'b1, 7'd0,   16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
            '{1'b0, 7'd0,   16'd100,  1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   -16'sd200, 1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'd300,  1'b1, 1'b0, 16'h0000},
            '{1'b1, 7'd2,   16'd5,    1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'd5,    1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'd5,    1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'd5,    1'b1, 1'b0, 16'h0000},
            '{1'b1, 7'd64,  16'h8000, 1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'h7FFF, 1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'h7FFF, 1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   -16'sd5,  1'b1, 1'b0, 16'h0000},
            '{1'b1, 7'd127, 16'd1,    1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'd2,    1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'd3,    1'b1, 1'b0, 16'h0000},
            '{1'b1, 7'd3,   16'd10,   1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'd20,   1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'd30,   1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'd40,   1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   16'd50,   1'b1, 1'b0, 16'h0000},
            '{1'b1, 7'd2,   -16'sd4,  1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   -16'sd4,  1'b0, 1'b0, 16'h0000},
            '{1'b0, 7'd0,   -16'sd1,  1'b1, 1'b0, 16'h0000}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].cfg) set_groups(plan[r].gc);
            send_sample(plan[r].sample, plan[r].last, plan[r].typed, plan[r].typed_value);
        end

        sent = 0;
        vec  = 0;
        while (sent < RANDOM_ITEMS) begin
            if (vec > 0 && $urandom_range(0, 3) == 0) set_groups(pick_groups());
            // force a dropped last sample, an exactly full store and a long overrun
            if (vec == 2)      len = MAX_ELEMENTS + 1;
            else if (vec == 5) len = MAX_ELEMENTS;
            else if (vec == 9) len = $urandom_range(MAX_ELEMENTS + 2, MAX_ELEMENTS + 4);
            else begin
                case ($urandom_range(0, 11))
                    0:       len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 4);
                    1, 2:    len = $urandom_range(20, MAX_ELEMENTS);
                    default: len = $urandom_range(1, 10);
                endcase
            end
            for (k = 0; k < len; k++) begin
                if (sent < RANDOM_ITEMS * 4 / 5 && $urandom_range(0, 4) == 0) hold_off();
                send_sample(pick_sample(), k == len - 1, 1'b0, '0);
                sent++;
            end
            vec++;
        end
        start <= 1'b0;

        while (expected_picks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
